// ===== rtl/wpa_pkg.sv =====
// wpa_pkg: shared types and constants for the worker pool autoscaler
// no dependencies; imported by worker_pool_autoscaler and wpa_checker
`default_nettype none

package wpa_pkg;

   localparam int unsigned DEFAULT_MAX_WORKERS = 8;

   // up threshold used for worker counts that never scale up
   localparam logic [19:0] NO_SCALE_THRESHOLD = 20'd999999;

   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // reset values of the configuration registers, the worker count and the active slots
   localparam logic [15:0] RST_UP_THR_TWO   = 16'd10;
   localparam logic [15:0] RST_UP_THR_THREE = 16'd20;
   localparam logic [15:0] RST_UP_THR_FOUR  = 16'd30;
   localparam logic [31:0] RST_COOLDOWN     = 32'd1000000;
   localparam logic [15:0] RST_DOWN_THR     = 16'd2;
   localparam logic [31:0] RST_DOWN_WAIT    = 32'd2000000;
   localparam logic [31:0] RST_IDLE_TIMEOUT = 32'd1000000;
   localparam logic [5:0]  RST_MIN_WORKERS  = 6'd2;
   localparam logic [5:0]  RST_WORKER_COUNT = 6'd2;
   localparam logic [5:0]  RST_ACTIVE_SLOTS = 6'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UP_THR_TWO   = 4'd0,
      CSR_UP_THR_THREE = 4'd1,
      CSR_UP_THR_FOUR  = 4'd2,
      CSR_COOLDOWN     = 4'd3,
      CSR_DOWN_THR     = 4'd4,
      CSR_DOWN_WAIT    = 4'd5,
      CSR_IDLE_TIMEOUT = 4'd6,
      CSR_MIN_WORKERS  = 4'd7
   } csr_index_type;

   typedef enum logic {
      ACT_TICK   = 1'b0,
      ACT_STATUS = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      DEC_NONE = 2'd0,
      DEC_UP   = 2'd1,
      DEC_DOWN = 2'd2
   } decision_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/worker_pool_autoscaler.sv =====
// worker_pool_autoscaler: slot table in two small memories, tick sequencer and result register
// depends on wpa_pkg
`default_nettype none

// Threshold autoscaler for a pool of up to MAX_WORKERS worker slots. A status item
// (req_tuser = 1) rewrites one slot's idle flag and completion time and gives no result.
// A tick item (req_tuser = 0) gives exactly one result: the block accepts it, evaluates
// scale-up and the low-queue timer, then, only when a scale-down is tried, scans the
// slots from count-1 down to min_workers (read the slot memories, then check), and last
// loads the result register, waiting there while an earlier result is still stalled.
// A tick can end before any scan. The scan reads the slot memories one slot at a time.
// The block takes one item at a time and takes the next one while a finished result
// still waits on rsp_tvalid. Slot memories need no clearing pass: per-slot valid bits
// make unwritten slots read as their reset values.
module worker_pool_autoscaler #(
   parameter int unsigned MAX_WORKERS = wpa_pkg::DEFAULT_MAX_WORKERS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // queue_len[15:0], now_us[47:16], worker_index[52:48], worker_idle[53],
   // done_time_us[85:54], zero fill
   input  wire  [wpa_pkg::REQ_DATA_W-1:0]       req_tdata,
   // action[0]
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // decision[1:0], worker_count[7:2], changed_slot[12:8], zero fill
   output logic [wpa_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [wpa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [wpa_pkg::CSR_DATA_W-1:0]       csr_data
);
   import wpa_pkg::*;

   localparam int unsigned IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam logic [5:0] MAX_CNT = 6'(MAX_WORKERS);

   // configuration registers
   logic [15:0] up_two_ff, up_three_ff, up_four_ff, down_thr_ff;
   logic [31:0] cooldown_ff, down_wait_ff, idle_timeout_ff;
   logic [5:0]  min_workers_ff;

   // control state
   state_type        state_ff, state_in;
   logic [5:0]       count_ff, count_in;
   logic [31:0]      last_ff, last_in;
   logic [31:0]      lqs_ff, lqs_in;
   logic [MAX_WORKERS-1:0] act_vld_ff, act_vld_in;
   logic [MAX_WORKERS-1:0] stat_vld_ff, stat_vld_in;
   logic [5:0]       scan_ff, scan_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [15:0]      q_ff, q_in;
   logic [31:0]      now_ff, now_in;
   logic [IDX_W-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   decision_type     res_dec_ff, res_dec_in;
   logic [5:0]       res_cnt_ff, res_cnt_in;
   logic [4:0]       res_slot_ff, res_slot_in;
   decision_type     out_dec_ff, out_dec_in;
   logic [5:0]       out_cnt_ff, out_cnt_in;
   logic [4:0]       out_slot_ff, out_slot_in;

   // slot memories: active flag, and {idle, last done time}
   logic             act_mem [MAX_WORKERS];
   logic [32:0]      stat_mem [MAX_WORKERS];
   logic             act_rd_ff;
   logic [32:0]      stat_rd_ff;
   logic             act_we, act_wd;
   logic [IDX_W-1:0] act_wa;
   logic             stat_we;
   logic [IDX_W-1:0] stat_wa;
   logic [32:0]      stat_wd;
   logic [IDX_W-1:0] rd_addr;
   logic [5:0]       rd_full;

   // request fields
   logic [15:0] f_queue;
   logic [31:0] f_now, f_done;
   logic [4:0]  f_index;
   logic        f_idle;
   logic        req_fire;

   // evaluation terms
   logic [31:0] since_scale, since_low, since_done;
   logic        cooled;
   logic [19:0] up_thr;
   logic        act_bit, idle_bit, hit, aged;
   logic [31:0] done_val;

   assign f_queue = req_tdata[15:0];
   assign f_now   = req_tdata[47:16];
   assign f_index = req_tdata[52:48];
   assign f_idle  = req_tdata[53];
   assign f_done  = req_tdata[85:54];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_slot_ff, out_cnt_ff, out_dec_ff};

   assign rd_full = scan_ff - 6'd1;
   assign rd_addr = rd_full[IDX_W-1:0];

   assign since_scale = now_ff - last_ff;
   assign since_low   = now_ff - lqs_ff;
   assign cooled      = (since_scale >= cooldown_ff);

   always_comb begin
      case (count_ff)
         6'd2:    up_thr = {4'd0, up_two_ff};
         6'd3:    up_thr = {4'd0, up_three_ff};
         6'd4:    up_thr = {4'd0, up_four_ff};
         default: up_thr = NO_SCALE_THRESHOLD;
      endcase
   end

   // unwritten slots read as their reset values
   assign act_bit  = act_vld_ff[addr_ff] ? act_rd_ff : (6'(addr_ff) < RST_ACTIVE_SLOTS);
   assign idle_bit = stat_vld_ff[addr_ff] ? stat_rd_ff[32] : 1'b1;
   assign done_val = stat_vld_ff[addr_ff] ? stat_rd_ff[31:0] : 32'd0;
   assign since_done = now_ff - done_val;
   assign hit  = act_bit && idle_bit;
   assign aged = (since_done >= idle_timeout_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      lqs_in       = lqs_ff;
      act_vld_in   = act_vld_ff;
      stat_vld_in  = stat_vld_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      q_in         = q_ff;
      now_in       = now_ff;
      cand_in      = cand_ff;
      addr_in      = addr_ff;
      res_dec_in   = res_dec_ff;
      res_cnt_in   = res_cnt_ff;
      res_slot_in  = res_slot_ff;
      out_dec_in   = out_dec_ff;
      out_cnt_in   = out_cnt_ff;
      out_slot_in  = out_slot_ff;
      act_we       = 1'b0;
      act_wa       = count_ff[IDX_W-1:0];
      act_wd       = 1'b1;
      stat_we      = 1'b0;
      stat_wa      = f_index[IDX_W-1:0];
      stat_wd      = {f_idle, f_done};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ACT_STATUS) begin
                  // out-of-range slots are dropped
                  if (6'(f_index) < MAX_CNT) begin
                     stat_we = 1'b1;
                     stat_vld_in[f_index[IDX_W-1:0]] = 1'b1;
                  end
               end else begin
                  q_in     = f_queue;
                  now_in   = f_now;
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            res_dec_in  = DEC_NONE;
            res_cnt_in  = count_ff;
            res_slot_in = 5'd0;
            state_in    = ST_DONE;
            if ((count_ff < MAX_CNT) && cooled && ({4'd0, q_ff} >= up_thr)) begin
               act_we      = 1'b1;
               act_wa      = count_ff[IDX_W-1:0];
               act_wd      = 1'b1;
               act_vld_in[count_ff[IDX_W-1:0]] = 1'b1;
               count_in    = count_ff + 6'd1;
               last_in     = now_ff;
               lqs_in      = 32'd0;
               res_dec_in  = DEC_UP;
               res_cnt_in  = count_ff + 6'd1;
               res_slot_in = count_ff[4:0];
            end else if ((count_ff > min_workers_ff) && cooled) begin
               if (q_ff >= down_thr_ff) begin
                  lqs_in = 32'd0;
               end else if (lqs_ff == 32'd0) begin
                  // a start at time zero leaves the timer stopped
                  lqs_in = now_ff;
               end else if (since_low >= down_wait_ff) begin
                  scan_in  = count_ff;
                  found_in = 1'b0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            addr_in  = rd_addr;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (hit && aged) begin
               // remove the highest active idle slot seen so far
               act_we      = 1'b1;
               act_wa      = found_ff ? cand_ff : addr_ff;
               act_wd      = 1'b0;
               act_vld_in[act_wa] = 1'b1;
               count_in    = count_ff - 6'd1;
               last_in     = now_ff;
               lqs_in      = 32'd0;
               res_dec_in  = DEC_DOWN;
               res_cnt_in  = count_ff - 6'd1;
               res_slot_in = 5'(act_wa);
               state_in    = ST_DONE;
            end else begin
               if (hit && !found_ff) begin
                  cand_in  = addr_ff;
                  found_in = 1'b1;
               end
               scan_in = scan_ff - 6'd1;
               if (scan_in > min_workers_ff) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_dec_in   = res_dec_ff;
               out_cnt_in   = res_cnt_ff;
               out_slot_in  = res_slot_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= RST_WORKER_COUNT;
         last_ff      <= 32'd0;
         lqs_ff       <= 32'd0;
         act_vld_ff   <= '0;
         stat_vld_ff  <= '0;
         scan_ff      <= 6'd0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         lqs_ff       <= lqs_in;
         act_vld_ff   <= act_vld_in;
         stat_vld_ff  <= stat_vld_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      now_ff      <= now_in;
      cand_ff     <= cand_in;
      addr_ff     <= addr_in;
      res_dec_ff  <= res_dec_in;
      res_cnt_ff  <= res_cnt_in;
      res_slot_ff <= res_slot_in;
      out_dec_ff  <= out_dec_in;
      out_cnt_ff  <= out_cnt_in;
      out_slot_ff <= out_slot_in;
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_wa] <= act_wd;
      end
      act_rd_ff <= act_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_mem[stat_wa] <= stat_wd;
      end
      stat_rd_ff <= stat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_two_ff       <= RST_UP_THR_TWO;
         up_three_ff     <= RST_UP_THR_THREE;
         up_four_ff      <= RST_UP_THR_FOUR;
         cooldown_ff     <= RST_COOLDOWN;
         down_thr_ff     <= RST_DOWN_THR;
         down_wait_ff    <= RST_DOWN_WAIT;
         idle_timeout_ff <= RST_IDLE_TIMEOUT;
         min_workers_ff  <= RST_MIN_WORKERS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UP_THR_TWO:   up_two_ff       <= csr_data[15:0];
            CSR_UP_THR_THREE: up_three_ff     <= csr_data[15:0];
            CSR_UP_THR_FOUR:  up_four_ff      <= csr_data[15:0];
            CSR_COOLDOWN:     cooldown_ff     <= csr_data;
            CSR_DOWN_THR:     down_thr_ff     <= csr_data[15:0];
            CSR_DOWN_WAIT:    down_wait_ff    <= csr_data;
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_data;
            CSR_MIN_WORKERS:  min_workers_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wpa_checker.sv =====
// wpa_checker: port-level assertions for worker_pool_autoscaler, with its bind
// depends on wpa_pkg and worker_pool_autoscaler
`default_nettype none

module wpa_checker #(
   parameter int unsigned MAX_WORKERS = wpa_pkg::DEFAULT_MAX_WORKERS
) (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             req_tuser,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [wpa_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import wpa_pkg::*;

   localparam logic [5:0] MAX_CNT = 6'(MAX_WORKERS);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no change reports slot zero and codes stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == DEC_NONE) |-> (rsp_tdata[12:8] == 5'd0))
      else $error("no-change result with nonzero slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[7:2] <= MAX_CNT))
      else $error("result decision or count out of range");

   // a status item never produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && req_tready && (req_tuser == ACT_STATUS) |=> !rsp_tvalid)
      else $error("result after status item");

   // a scale-up names the slot at the old count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == DEC_UP) |->
         (6'(rsp_tdata[12:8]) + 6'd1 == rsp_tdata[7:2]))
      else $error("scale-up slot does not match count");

endmodule

bind worker_pool_autoscaler wpa_checker #(.MAX_WORKERS(MAX_WORKERS)) u_wpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
